// ===== rtl/jse_pkg.sv =====
// Shared types, constants and tables for the Jacobi eigensolver unit.
// Used by jse_cordic, jse_mac and jacobi_symmetric_eigensolver_unit.
package jse_pkg;

   // Matrix size and derived index widths.
   localparam int MAX_N   = 8;
   localparam int IDX_W   = $clog2(MAX_N);
   localparam int ADDR_W  = 2 * IDX_W;
   localparam int N_W     = $clog2(MAX_N + 1);
   localparam int DEPTH   = MAX_N * MAX_N;

   // CORDIC settings and fixed-point constants.
   localparam int CORDIC_STEPS = 24;
   localparam int OPND_W       = 34;
   localparam int ZW           = 36;
   localparam logic signed [31:0] ONE_Q30  = 32'sd1073741824;
   localparam logic signed [63:0] GAIN_Q30 = 64'sd652032874;
   localparam logic signed [ZW-1:0] PI_Q30 = 36'sd3373259426;
   localparam logic signed [63:0] NORM_LIMIT = 64'sd288230376151711744;

   // Configuration register indexes.
   localparam logic [1:0] REG_SIZE  = 2'd0;
   localparam logic [1:0] REG_TOL   = 2'd1;
   localparam logic [1:0] REG_LIMIT = 2'd2;

   // Sequencer states of the top level.
   typedef enum logic [4:0] {
      ST_IDLE, ST_VINIT, ST_ROT_CHK, ST_PV_RD, ST_PV_CMP, ST_PV_DEC,
      ST_RD_PP, ST_RD_QQ, ST_RD_PQ, ST_CORD_GO, ST_CORD_WAIT, ST_UPD, ST_DIAG,
      ST_EIG_RD, ST_EIG_WR, ST_SI_RD, ST_SI_LD, ST_SJ_RD, ST_SJ_CMP, ST_SWAP,
      ST_OUT_RD, ST_OUT_EM
   } top_state_type;

   // Which rotation sweep is running.
   typedef enum logic [1:0] {
      PASS_COL, PASS_ROW, PASS_VEC
   } pass_type;

   // CORDIC sequencer states.
   typedef enum logic [2:0] {
      CS_IDLE, CS_NORM, CS_VEC, CS_ROT, CS_DONE
   } cordic_state_type;

   // Control of one multiply-accumulate issue.
   typedef struct packed {
      logic en;
      logic clr;
      logic neg;
      logic dbl;
   } mac_ctl_type;

   // Arctangent of 2^-i in radians, Q.30.
   function automatic logic [29:0] atan_q30(input logic [4:0] idx);
      logic [29:0] v;
      case (idx)
         5'd0:  v = 30'd843314857;
         5'd1:  v = 30'd497837829;
         5'd2:  v = 30'd263043837;
         5'd3:  v = 30'd133525159;
         5'd4:  v = 30'd67021687;
         5'd5:  v = 30'd33543516;
         5'd6:  v = 30'd16775851;
         5'd7:  v = 30'd8388437;
         5'd8:  v = 30'd4194283;
         5'd9:  v = 30'd2097149;
         5'd10: v = 30'd1048576;
         5'd11: v = 30'd524288;
         5'd12: v = 30'd262144;
         5'd13: v = 30'd131072;
         5'd14: v = 30'd65536;
         5'd15: v = 30'd32768;
         5'd16: v = 30'd16384;
         5'd17: v = 30'd8192;
         5'd18: v = 30'd4096;
         5'd19: v = 30'd2048;
         5'd20: v = 30'd1024;
         5'd21: v = 30'd512;
         5'd22: v = 30'd256;
         5'd23: v = 30'd128;
         5'd24: v = 30'd64;
         5'd25: v = 30'd32;
         5'd26: v = 30'd16;
         5'd27: v = 30'd8;
         5'd28: v = 30'd4;
         5'd29: v = 30'd2;
         5'd30: v = 30'd1;
         default: v = 30'd0;
      endcase
      return v;
   endfunction

endpackage

// ===== rtl/jse_cordic.sv =====
// Iterative CORDIC: vectoring to get the full angle, then rotation by the half
// angle to get its cosine and sine in Q2.30. One shift-add step per cycle. Uses jse_pkg.
module jse_cordic import jse_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     go,
   input  logic signed [OPND_W-1:0] vec_x,
   input  logic signed [OPND_W-1:0] vec_y,
   output logic                     done,
   output logic signed [31:0]       cos_out,
   output logic signed [31:0]       sin_out
);

   cordic_state_type       st_ff, st_in;
   logic signed [63:0]     x_ff, x_in, y_ff, y_in;
   logic signed [ZW-1:0]   z_ff, z_in;
   logic [4:0]             i_ff, i_in;

   logic signed [63:0]     xs, ys, xa, ya, ex, ey, xn, yn;
   logic signed [ZW-1:0]   at, zn;
   logic                   dir, below_lim;

   localparam logic [4:0] LAST = 5'(CORDIC_STEPS - 1);

   // Shared shift-add step; dir high rotates counterclockwise.
   always_comb begin
      xs        = x_ff >>> i_ff;
      ys        = y_ff >>> i_ff;
      at        = signed'(ZW'(atan_q30(i_ff)));
      dir       = (st_ff == CS_ROT) ? (z_ff >= 0) : !(y_ff > 0);
      xn        = dir ? (x_ff - ys) : (x_ff + ys);
      yn        = dir ? (y_ff + xs) : (y_ff - xs);
      zn        = dir ? (z_ff - at) : (z_ff + at);
      xa        = (x_ff < 0) ? -x_ff : x_ff;
      ya        = (y_ff < 0) ? -y_ff : y_ff;
      below_lim = (xa < NORM_LIMIT) && (ya < NORM_LIMIT);
      ex        = 64'(vec_x);
      ey        = 64'(vec_y);
   end

   // Sequencer: fold, normalize, vector, then rotate; a zero vector only rotates.
   always_comb begin
      st_in = st_ff;
      x_in  = x_ff;
      y_in  = y_ff;
      z_in  = z_ff;
      i_in  = i_ff;
      unique case (st_ff)
         CS_IDLE: begin
            if (go) begin
               i_in = '0;
               if (vec_x == 0 && vec_y == 0) begin
                  z_in  = '0;
                  x_in  = GAIN_Q30;
                  y_in  = '0;
                  st_in = CS_ROT;
               end else if (vec_x < 0) begin
                  z_in  = (vec_y >= 0) ? PI_Q30 : -PI_Q30;
                  x_in  = -ex;
                  y_in  = -ey;
                  st_in = CS_NORM;
               end else begin
                  z_in  = '0;
                  x_in  = ex;
                  y_in  = ey;
                  st_in = CS_NORM;
               end
            end
         end
         CS_NORM: begin
            if (below_lim) begin
               x_in = x_ff <<< 1;
               y_in = y_ff <<< 1;
            end else begin
               st_in = CS_VEC;
            end
         end
         CS_VEC: begin
            if (i_ff == LAST) begin
               z_in  = zn >>> 1;
               x_in  = GAIN_Q30;
               y_in  = '0;
               i_in  = '0;
               st_in = CS_ROT;
            end else begin
               x_in = xn;
               y_in = yn;
               z_in = zn;
               i_in = i_ff + 5'd1;
            end
         end
         CS_ROT: begin
            x_in = xn;
            y_in = yn;
            z_in = zn;
            if (i_ff == LAST) begin
               st_in = CS_DONE;
            end else begin
               i_in = i_ff + 5'd1;
            end
         end
         CS_DONE: begin
            st_in = CS_IDLE;
         end
         default: begin
            st_in = CS_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= CS_IDLE;
      end else begin
         st_ff <= st_in;
      end
      x_ff <= x_in;
      y_ff <= y_in;
      z_ff <= z_in;
      i_ff <= i_in;
   end

   assign done    = (st_ff == CS_DONE);
   assign cos_out = x_ff[31:0];
   assign sin_out = y_ff[31:0];

endmodule

// ===== rtl/jse_mac.sv =====
// Two-stage multiply-accumulate with round-half-up to Q.30 and 32-bit saturation.
// Terms pass the product register, then the accumulator register. Uses jse_pkg.
module jse_mac import jse_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  mac_ctl_type        ctl,
   input  logic signed [31:0] opa,
   input  logic signed [31:0] opb,
   output logic signed [31:0] result
);

   mac_ctl_type        ctl_ff;
   logic signed [63:0] prod_ff, prod_in;
   logic signed [65:0] acc_ff, acc_in, term, base;
   logic signed [66:0] rsum;
   logic signed [36:0] rnd;

   // Stage one: product.
   assign prod_in = opa * opb;

   // Stage two: accumulate the signed term.
   always_comb begin
      term   = ctl_ff.dbl ? (66'(prod_ff) <<< 1) : 66'(prod_ff);
      base   = ctl_ff.clr ? 66'sd0 : acc_ff;
      acc_in = acc_ff;
      if (ctl_ff.en) begin
         acc_in = ctl_ff.neg ? (base - term) : (base + term);
      end
   end

   // Round half up, shift to the target format, saturate.
   always_comb begin
      rsum = 67'(acc_ff) + 67'sd536870912;
      rnd  = 37'(rsum >>> 30);
      if (rnd > 37'sd2147483647) begin
         result = 32'sh7fffffff;
      end else if (rnd < -37'sd2147483648) begin
         result = 32'sh80000000;
      end else begin
         result = rnd[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else begin
         ctl_ff <= ctl;
      end
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

endmodule

// ===== rtl/jacobi_symmetric_eigensolver_unit.sv =====
// Top level of the Jacobi eigensolver: load sequencer, matrix memories, sort and
// result sweep. Depends on jse_pkg, jse_cordic and jse_mac.
//
// Usage: write size_in_use, tolerance and rotation_limit over the APB port while
// the block is idle. Then feed the n*n matrix entries row-major on req_entry, one
// per cycle if desired, each taken when start is high and busy is low. The size
// is latched at the first entry of a load. After the last entry busy rises and
// the block runs Jacobi rotations, sorts the eigenpairs and emits n*n results
// on the rsp_ ports, each marked by rsp_valid for one cycle; rsp_last_of_run
// flags the final one. The receiver cannot stall. After the last entry the
// block sets the eigenvector matrix to identity, then per rotation runs a pivot
// search, the CORDIC (24 vectoring and 24 rotation steps, up to 58 normalize
// steps) and the column, row and vector updates, all on one shared multiplier
// and one CORDIC unit, then the diagonal copy, the swap sort and the output.
// Reset returns the block to idle with an empty load and registers at size 3,
// tolerance 1, limit 100.
module jacobi_symmetric_eigensolver_unit import jse_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [31:0] req_entry,
   output logic               rsp_valid,
   output logic [2:0]         rsp_pair_index,
   output logic [2:0]         rsp_row_index,
   output logic signed [31:0] rsp_eigenvalue,
   output logic signed [31:0] rsp_component,
   output logic               rsp_last_of_run,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [3:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);

   // Memories.
   logic signed [31:0] work_mem [DEPTH];
   logic signed [31:0] vec_mem  [DEPTH];
   logic signed [31:0] eig_mem  [MAX_N];

   logic                  wm_we, vm_we, eg_we;
   logic [ADDR_W-1:0]     wm_waddr, wm_raddr, vm_waddr, vm_raddr;
   logic [IDX_W-1:0]      eg_waddr, eg_raddr;
   logic signed [31:0]    wm_wdata, vm_wdata, eg_wdata;
   logic signed [31:0]    wm_rd_ff, vm_rd_ff, eg_rd_ff;

   // Sequencer state.
   top_state_type         st_ff, st_in;
   pass_type              pass_ff, pass_in;
   logic [3:0]            step_ff, step_in;
   logic [IDX_W-1:0]      ld_row_ff, ld_row_in, ld_col_ff, ld_col_in;
   logic [N_W-1:0]        n_ff, n_in;
   logic [IDX_W-1:0]      i_ff, i_in, j_ff, j_in, k_ff, k_in, p_ff, p_in, q_ff, q_in;
   logic [31:0]           maxv_ff, maxv_in;
   logic [7:0]            rot_ff, rot_in;
   logic signed [31:0]    app_ff, app_in, aqq_ff, aqq_in, apq_ff, apq_in;
   logic signed [31:0]    a_ff, a_in, b_ff, b_in;
   logic signed [31:0]    c2_ff, c2_in, s2_ff, s2_in, sc2_ff, sc2_in;
   logic signed [31:0]    ei_ff, ei_in;

   // Configuration registers.
   logic [3:0]            size_ff, size_in;
   logic [15:0]           tol_ff, tol_in;
   logic [7:0]            lim_ff, lim_in;

   // Shared units.
   mac_ctl_type           mctl;
   logic signed [31:0]    mopa, mopb, mres;
   logic                  cgo, cdone;
   logic signed [OPND_W-1:0] cx, cy;
   logic signed [31:0]    cos_w, sin_w;

   // Helpers.
   logic [IDX_W-1:0]      nm1, n_eff_m1;
   logic [N_W-1:0]        n_clamp, n_eff;
   logic                  first, sort_adv;
   logic [ADDR_W-1:0]     a_addr, b_addr;
   logic signed [31:0]    upd_rd;
   logic [31:0]           mag;

   jse_cordic u_cordic (
      .clock   (clock),
      .reset   (reset),
      .go      (cgo),
      .vec_x   (cx),
      .vec_y   (cy),
      .done    (cdone),
      .cos_out (cos_w),
      .sin_out (sin_w)
   );

   jse_mac u_mac (
      .clock  (clock),
      .reset  (reset),
      .ctl    (mctl),
      .opa    (mopa),
      .opb    (mopb),
      .result (mres)
   );

   // Size clamp and derived counts.
   always_comb begin
      if (size_ff < 4'd2) begin
         n_clamp = N_W'(2);
      end else if (size_ff > 4'(MAX_N)) begin
         n_clamp = N_W'(MAX_N);
      end else begin
         n_clamp = N_W'(size_ff);
      end
      first    = (ld_row_ff == '0) && (ld_col_ff == '0);
      n_eff    = first ? n_clamp : n_ff;
      n_eff_m1 = IDX_W'(n_eff - N_W'(1));
      nm1      = IDX_W'(n_ff - N_W'(1));
      a_addr   = (pass_ff == PASS_ROW) ? {p_ff, k_ff} : {k_ff, p_ff};
      b_addr   = (pass_ff == PASS_ROW) ? {q_ff, k_ff} : {k_ff, q_ff};
      upd_rd   = (pass_ff == PASS_VEC) ? vm_rd_ff : wm_rd_ff;
      mag      = wm_rd_ff[31] ? (~wm_rd_ff + 32'd1) : wm_rd_ff;
      cx       = OPND_W'(aqq_ff) - OPND_W'(app_ff);
      cy       = {wm_rd_ff[31], wm_rd_ff, 1'b0};
   end

   // Main sequencer.
   always_comb begin
      st_in     = st_ff;
      pass_in   = pass_ff;
      step_in   = step_ff;
      ld_row_in = ld_row_ff;
      ld_col_in = ld_col_ff;
      n_in      = n_ff;
      i_in      = i_ff;
      j_in      = j_ff;
      k_in      = k_ff;
      p_in      = p_ff;
      q_in      = q_ff;
      maxv_in   = maxv_ff;
      rot_in    = rot_ff;
      app_in    = app_ff;
      aqq_in    = aqq_ff;
      apq_in    = apq_ff;
      a_in      = a_ff;
      b_in      = b_ff;
      c2_in     = c2_ff;
      s2_in     = s2_ff;
      sc2_in    = sc2_ff;
      ei_in     = ei_ff;
      wm_we     = 1'b0;
      wm_waddr  = '0;
      wm_wdata  = '0;
      wm_raddr  = '0;
      vm_we     = 1'b0;
      vm_waddr  = '0;
      vm_wdata  = '0;
      vm_raddr  = '0;
      eg_we     = 1'b0;
      eg_waddr  = '0;
      eg_wdata  = '0;
      eg_raddr  = '0;
      mctl      = '0;
      mopa      = '0;
      mopb      = '0;
      cgo       = 1'b0;
      rsp_valid = 1'b0;
      sort_adv  = 1'b0;

      unique case (st_ff)
         // Take matrix entries row-major.
         ST_IDLE: begin
            if (start) begin
               if (first) begin
                  n_in = n_clamp;
               end
               wm_we    = 1'b1;
               wm_waddr = {ld_row_ff, ld_col_ff};
               wm_wdata = req_entry;
               if (ld_col_ff == n_eff_m1) begin
                  ld_col_in = '0;
                  if (ld_row_ff == n_eff_m1) begin
                     ld_row_in = '0;
                     i_in      = '0;
                     j_in      = '0;
                     rot_in    = '0;
                     st_in     = ST_VINIT;
                  end else begin
                     ld_row_in = ld_row_ff + 1'b1;
                  end
               end else begin
                  ld_col_in = ld_col_ff + 1'b1;
               end
            end
         end
         // Set the eigenvector matrix to identity.
         ST_VINIT: begin
            vm_we    = 1'b1;
            vm_waddr = {i_ff, j_ff};
            vm_wdata = (i_ff == j_ff) ? ONE_Q30 : 32'sd0;
            if (j_ff == nm1) begin
               j_in = '0;
               if (i_ff == nm1) begin
                  st_in = ST_ROT_CHK;
               end else begin
                  i_in = i_ff + 1'b1;
               end
            end else begin
               j_in = j_ff + 1'b1;
            end
         end
         // Rotation budget check and pivot search setup.
         ST_ROT_CHK: begin
            if (rot_ff == lim_ff) begin
               i_in  = '0;
               st_in = ST_EIG_RD;
            end else begin
               i_in    = '0;
               j_in    = IDX_W'(1);
               p_in    = '0;
               q_in    = IDX_W'(1);
               maxv_in = '0;
               st_in   = ST_PV_RD;
            end
         end
         ST_PV_RD: begin
            wm_raddr = {i_ff, j_ff};
            st_in    = ST_PV_CMP;
         end
         // Keep the first largest magnitude.
         ST_PV_CMP: begin
            if (mag > maxv_ff) begin
               maxv_in = mag;
               p_in    = i_ff;
               q_in    = j_ff;
            end
            st_in = ST_PV_RD;
            if (j_ff == nm1) begin
               if (i_ff == IDX_W'(nm1 - 1'b1)) begin
                  st_in = ST_PV_DEC;
               end else begin
                  i_in = i_ff + 1'b1;
                  j_in = i_ff + IDX_W'(2);
               end
            end else begin
               j_in = j_ff + 1'b1;
            end
         end
         ST_PV_DEC: begin
            if (maxv_ff < {16'd0, tol_ff}) begin
               i_in  = '0;
               st_in = ST_EIG_RD;
            end else begin
               st_in = ST_RD_PP;
            end
         end
         // Fetch the pivot block.
         ST_RD_PP: begin
            wm_raddr = {p_ff, p_ff};
            st_in    = ST_RD_QQ;
         end
         ST_RD_QQ: begin
            wm_raddr = {q_ff, q_ff};
            app_in   = wm_rd_ff;
            st_in    = ST_RD_PQ;
         end
         ST_RD_PQ: begin
            wm_raddr = {p_ff, q_ff};
            aqq_in   = wm_rd_ff;
            st_in    = ST_CORD_GO;
         end
         ST_CORD_GO: begin
            apq_in = wm_rd_ff;
            cgo    = 1'b1;
            st_in  = ST_CORD_WAIT;
         end
         ST_CORD_WAIT: begin
            if (cdone) begin
               pass_in = PASS_COL;
               k_in    = '0;
               step_in = '0;
               st_in   = ST_UPD;
            end
         end
         // Rotate one pair of entries per run through the update steps.
         ST_UPD: begin
            step_in = step_ff + 4'd1;
            case (step_ff)
               4'd0: begin
                  wm_raddr = a_addr;
                  vm_raddr = a_addr;
               end
               4'd1: begin
                  wm_raddr = b_addr;
                  vm_raddr = b_addr;
                  a_in     = upd_rd;
               end
               4'd2: begin
                  b_in     = upd_rd;
                  mctl.en  = 1'b1;
                  mctl.clr = 1'b1;
                  mopa     = cos_w;
                  mopb     = a_ff;
               end
               4'd3: begin
                  mctl.en  = 1'b1;
                  mctl.neg = 1'b1;
                  mopa     = sin_w;
                  mopb     = b_ff;
               end
               4'd4: begin
                  mctl.en  = 1'b1;
                  mctl.clr = 1'b1;
                  mopa     = sin_w;
                  mopb     = a_ff;
               end
               4'd5: begin
                  mctl.en = 1'b1;
                  mopa    = cos_w;
                  mopb    = b_ff;
                  if (pass_ff == PASS_VEC) begin
                     vm_we    = 1'b1;
                     vm_waddr = a_addr;
                     vm_wdata = mres;
                  end else begin
                     wm_we    = 1'b1;
                     wm_waddr = a_addr;
                     wm_wdata = mres;
                  end
               end
               4'd7: begin
                  step_in = '0;
                  if (pass_ff == PASS_VEC) begin
                     vm_we    = 1'b1;
                     vm_waddr = b_addr;
                     vm_wdata = mres;
                  end else begin
                     wm_we    = 1'b1;
                     wm_waddr = b_addr;
                     wm_wdata = mres;
                  end
                  if (k_ff == nm1) begin
                     k_in = '0;
                     unique case (pass_ff)
                        PASS_COL: pass_in = PASS_ROW;
                        PASS_ROW: st_in   = ST_DIAG;
                        PASS_VEC: begin
                           rot_in = rot_ff + 8'd1;
                           st_in  = ST_ROT_CHK;
                        end
                        default: st_in = ST_ROT_CHK;
                     endcase
                  end else begin
                     k_in = k_ff + 1'b1;
                  end
               end
               default: begin
               end
            endcase
         end
         // New diagonal from the original pivot block, then zero the pivot.
         ST_DIAG: begin
            step_in = step_ff + 4'd1;
            case (step_ff)
               4'd0: begin
                  mctl.en  = 1'b1;
                  mctl.clr = 1'b1;
                  mopa     = cos_w;
                  mopb     = cos_w;
               end
               4'd1: begin
                  mctl.en  = 1'b1;
                  mctl.clr = 1'b1;
                  mopa     = sin_w;
                  mopb     = sin_w;
               end
               4'd2: begin
                  mctl.en  = 1'b1;
                  mctl.clr = 1'b1;
                  mctl.dbl = 1'b1;
                  mopa     = sin_w;
                  mopb     = cos_w;
                  c2_in    = mres;
               end
               4'd3: s2_in  = mres;
               4'd4: sc2_in = mres;
               4'd5: begin
                  mctl.en  = 1'b1;
                  mctl.clr = 1'b1;
                  mopa     = c2_ff;
                  mopb     = app_ff;
               end
               4'd6: begin
                  mctl.en  = 1'b1;
                  mctl.neg = 1'b1;
                  mopa     = sc2_ff;
                  mopb     = apq_ff;
               end
               4'd7: begin
                  mctl.en = 1'b1;
                  mopa    = s2_ff;
                  mopb    = aqq_ff;
               end
               4'd8: begin
                  mctl.en  = 1'b1;
                  mctl.clr = 1'b1;
                  mopa     = s2_ff;
                  mopb     = app_ff;
               end
               4'd9: begin
                  mctl.en  = 1'b1;
                  mopa     = sc2_ff;
                  mopb     = apq_ff;
                  wm_we    = 1'b1;
                  wm_waddr = {p_ff, p_ff};
                  wm_wdata = mres;
               end
               4'd10: begin
                  mctl.en = 1'b1;
                  mopa    = c2_ff;
                  mopb    = aqq_ff;
               end
               4'd12: begin
                  wm_we    = 1'b1;
                  wm_waddr = {q_ff, q_ff};
                  wm_wdata = mres;
               end
               4'd13: begin
                  wm_we    = 1'b1;
                  wm_waddr = {p_ff, q_ff};
               end
               4'd14: begin
                  wm_we    = 1'b1;
                  wm_waddr = {q_ff, p_ff};
                  step_in  = '0;
                  k_in     = '0;
                  pass_in  = PASS_VEC;
                  st_in    = ST_UPD;
               end
               default: begin
               end
            endcase
         end
         // Copy the diagonal into the eigenvalue store.
         ST_EIG_RD: begin
            wm_raddr = {i_ff, i_ff};
            st_in    = ST_EIG_WR;
         end
         ST_EIG_WR: begin
            eg_we    = 1'b1;
            eg_waddr = i_ff;
            eg_wdata = wm_rd_ff;
            if (i_ff == nm1) begin
               i_in  = '0;
               st_in = ST_SI_RD;
            end else begin
               i_in  = i_ff + 1'b1;
               st_in = ST_EIG_RD;
            end
         end
         // Swap sort; entry i lives in ei_ff during its inner loop.
         ST_SI_RD: begin
            eg_raddr = i_ff;
            st_in    = ST_SI_LD;
         end
         ST_SI_LD: begin
            ei_in = eg_rd_ff;
            j_in  = i_ff + 1'b1;
            st_in = ST_SJ_RD;
         end
         ST_SJ_RD: begin
            eg_raddr = j_ff;
            st_in    = ST_SJ_CMP;
         end
         ST_SJ_CMP: begin
            if (ei_ff < eg_rd_ff) begin
               eg_we    = 1'b1;
               eg_waddr = j_ff;
               eg_wdata = ei_ff;
               ei_in    = eg_rd_ff;
               k_in     = '0;
               step_in  = '0;
               st_in    = ST_SWAP;
            end else begin
               sort_adv = 1'b1;
            end
         end
         // Swap eigenvector columns i and j, one row per run through the swap steps.
         ST_SWAP: begin
            step_in = step_ff + 4'd1;
            case (step_ff)
               4'd0: vm_raddr = {k_ff, i_ff};
               4'd1: begin
                  vm_raddr = {k_ff, j_ff};
                  a_in     = vm_rd_ff;
               end
               4'd2: begin
                  vm_we    = 1'b1;
                  vm_waddr = {k_ff, i_ff};
                  vm_wdata = vm_rd_ff;
               end
               default: begin
                  vm_we    = 1'b1;
                  vm_waddr = {k_ff, j_ff};
                  vm_wdata = a_ff;
                  step_in  = '0;
                  if (k_ff == nm1) begin
                     sort_adv = 1'b1;
                  end else begin
                     k_in = k_ff + 1'b1;
                  end
               end
            endcase
         end
         // Emit results pair-major, row-minor.
         ST_OUT_RD: begin
            eg_raddr = i_ff;
            vm_raddr = {j_ff, i_ff};
            st_in    = ST_OUT_EM;
         end
         ST_OUT_EM: begin
            rsp_valid = 1'b1;
            st_in     = ST_OUT_RD;
            if (j_ff == nm1) begin
               j_in = '0;
               if (i_ff == nm1) begin
                  i_in  = '0;
                  st_in = ST_IDLE;
               end else begin
                  i_in = i_ff + 1'b1;
               end
            end else begin
               j_in = j_ff + 1'b1;
            end
         end
         default: begin
            st_in = ST_IDLE;
         end
      endcase

      // Advance the sort's inner loop; close entry i at its end.
      if (sort_adv) begin
         if (j_ff == nm1) begin
            eg_we    = 1'b1;
            eg_waddr = i_ff;
            eg_wdata = ei_in;
            if (i_ff == IDX_W'(nm1 - 1'b1)) begin
               i_in  = '0;
               j_in  = '0;
               st_in = ST_OUT_RD;
            end else begin
               i_in  = i_ff + 1'b1;
               st_in = ST_SI_RD;
            end
         end else begin
            j_in  = j_ff + 1'b1;
            st_in = ST_SJ_RD;
         end
      end
   end

   // Configuration writes.
   always_comb begin
      size_in = size_ff;
      tol_in  = tol_ff;
      lim_in  = lim_ff;
      if (psel && penable && pwrite) begin
         unique case (paddr[3:2])
            REG_SIZE:  size_in = pwdata[3:0];
            REG_TOL:   tol_in  = pwdata[15:0];
            REG_LIMIT: lim_in  = pwdata[7:0];
            default: begin
            end
         endcase
      end
   end

   // Configuration reads.
   always_comb begin
      unique case (paddr[3:2])
         REG_SIZE:  prdata = {28'd0, size_ff};
         REG_TOL:   prdata = {16'd0, tol_ff};
         REG_LIMIT: prdata = {24'd0, lim_ff};
         default:   prdata = '0;
      endcase
   end

   // Control and payload registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff     <= ST_IDLE;
         ld_row_ff <= '0;
         ld_col_ff <= '0;
         size_ff   <= 4'd3;
         tol_ff    <= 16'd1;
         lim_ff    <= 8'd100;
      end else begin
         st_ff     <= st_in;
         ld_row_ff <= ld_row_in;
         ld_col_ff <= ld_col_in;
         size_ff   <= size_in;
         tol_ff    <= tol_in;
         lim_ff    <= lim_in;
      end
      pass_ff <= pass_in;
      step_ff <= step_in;
      n_ff    <= n_in;
      i_ff    <= i_in;
      j_ff    <= j_in;
      k_ff    <= k_in;
      p_ff    <= p_in;
      q_ff    <= q_in;
      maxv_ff <= maxv_in;
      rot_ff  <= rot_in;
      app_ff  <= app_in;
      aqq_ff  <= aqq_in;
      apq_ff  <= apq_in;
      a_ff    <= a_in;
      b_ff    <= b_in;
      c2_ff   <= c2_in;
      s2_ff   <= s2_in;
      sc2_ff  <= sc2_in;
      ei_ff   <= ei_in;
   end

   // Working matrix memory.
   always_ff @(posedge clock) begin
      if (wm_we) begin
         work_mem[wm_waddr] <= wm_wdata;
      end
      wm_rd_ff <= work_mem[wm_raddr];
   end

   // Eigenvector memory.
   always_ff @(posedge clock) begin
      if (vm_we) begin
         vec_mem[vm_waddr] <= vm_wdata;
      end
      vm_rd_ff <= vec_mem[vm_raddr];
   end

   // Eigenvalue store.
   always_ff @(posedge clock) begin
      if (eg_we) begin
         eig_mem[eg_waddr] <= eg_wdata;
      end
      eg_rd_ff <= eig_mem[eg_raddr];
   end

   assign busy            = (st_ff != ST_IDLE);
   assign pready          = 1'b1;
   assign rsp_pair_index  = 3'(i_ff);
   assign rsp_row_index   = 3'(j_ff);
   assign rsp_eigenvalue  = eg_rd_ff;
   assign rsp_component   = vm_rd_ff;
   assign rsp_last_of_run = (i_ff == nm1) && (j_ff == nm1);

endmodule

// ===== tb/sv/tb.sv =====
// Self-checking testbench for jacobi_symmetric_eigensolver_unit.
// Depends on jse_pkg and the unit's RTL; holds its own fixed-point eigensolver predictor.
module tb import jse_pkg::*; ();

   localparam int CYCLE_LIMIT  = 40000000;
   localparam int ITEM_TARGET  = 460;
   localparam int DRAIN_CYCLES = 40;
   localparam logic [3:0] ADDR_SIZE  = 4'(4 * REG_SIZE);
   localparam logic [3:0] ADDR_TOL   = 4'(4 * REG_TOL);
   localparam logic [3:0] ADDR_LIMIT = 4'(4 * REG_LIMIT);
   localparam longint HALF_LSB = 64'sd536870912;

   typedef struct {
      logic [2:0]         pair_index;
      logic [2:0]         row_index;
      logic signed [31:0] eigenvalue;
      logic signed [31:0] component;
      logic               last_of_run;
   } eigen_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic signed [31:0] req_entry = '0;
   logic psel = 1'b0;
   logic penable = 1'b0;
   logic pwrite = 1'b0;
   logic [3:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic busy, rsp_valid, rsp_last_of_run, pready;
   logic [2:0] rsp_pair_index, rsp_row_index;
   logic signed [31:0] rsp_eigenvalue, rsp_component;
   logic [31:0] prdata;

   jacobi_symmetric_eigensolver_unit u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_entry(req_entry),
      .rsp_valid(rsp_valid), .rsp_pair_index(rsp_pair_index),
      .rsp_row_index(rsp_row_index), .rsp_eigenvalue(rsp_eigenvalue),
      .rsp_component(rsp_component), .rsp_last_of_run(rsp_last_of_run),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   // Predictor state: matrices, eigenvalues, load progress and register copies.
   logic signed [31:0] mat_work [DEPTH];
   logic signed [31:0] mat_vec [DEPTH];
   logic signed [31:0] eig_vals [MAX_N];
   int unsigned load_pos = 0;
   int unsigned dim_latched = 3;
   logic [3:0]  cfg_size = 4'd3;
   logic [15:0] cfg_tol = 16'd1;
   logic [7:0]  cfg_limit = 8'd100;

   eigen_result_type expected_q[$];
   logic signed [31:0] entry_q[$];
   int unsigned entries_sent = 0;
   int unsigned matrices_done = 0;
   int unsigned results_checked = 0;
   int unsigned mismatch_count = 0;
   int unsigned cycle_count = 0;
   int burst_left = 8;
   int gap_left = 0;

   longint arctan_tab [32] = '{
      843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
      16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072,
      65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32,
      16, 8, 4, 2, 1, 0};

   // Clock generation.
   initial begin
      forever #5 clock = ~clock;
   end

   function automatic logic signed [31:0] clip32(input longint v);
      if (v > 64'sd2147483647) return 32'sh7fffffff;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return v[31:0];
   endfunction

   function automatic longint round_q30(input longint v);
      return (v + HALF_LSB) >>> 30;
   endfunction

   function automatic longint abs64(input longint v);
      return (v < 0) ? -v : v;
   endfunction

   // CORDIC vectoring for the full angle, then rotation by half of it.
   function automatic void half_angle_trig(input longint y_in, input longint x_in,
                                           output longint c, output longint s);
      longint x, y, z, t, phi, xr, yr;
      x = x_in; y = y_in; z = 0; xr = GAIN_Q30; yr = 0;
      if (x != 0 || y != 0) begin
         if (x < 0) begin
            z = (y >= 0) ? longint'(PI_Q30) : -longint'(PI_Q30);
            x = -x;
            y = -y;
         end
         while (abs64(x) < NORM_LIMIT && abs64(y) < NORM_LIMIT) begin
            x = x * 2;
            y = y * 2;
         end
         for (int i = 0; i < CORDIC_STEPS; i++) begin
            if (y > 0) begin
               t = x + (y >>> i); y = y - (x >>> i); x = t; z += arctan_tab[i];
            end else begin
               t = x - (y >>> i); y = y + (x >>> i); x = t; z -= arctan_tab[i];
            end
         end
      end
      phi = z >>> 1;
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         if (phi >= 0) begin
            t = xr - (yr >>> i); yr = yr + (xr >>> i); xr = t; phi -= arctan_tab[i];
         end else begin
            t = xr + (yr >>> i); yr = yr - (xr >>> i); xr = t; phi += arctan_tab[i];
         end
      end
      c = xr;
      s = yr;
   endfunction

   // Rotations, diagonal copy and descending swap sort for a completed load.
   function automatic void solve_matrix();
      int n, p, q;
      longint maxv, v, app, aqq, apq, c, s, c2, s2, sc2, a, b;
      logic signed [31:0] t;
      n = dim_latched;
      for (int rot = 0; rot < cfg_limit; rot++) begin
         p = 0; q = 1; maxv = 0;
         for (int i = 0; i < n; i++)
            for (int j = i + 1; j < n; j++) begin
               v = abs64(longint'(mat_work[i*n+j]));
               if (v > maxv) begin
                  maxv = v; p = i; q = j;
               end
            end
         if (maxv < longint'(cfg_tol)) break;
         app = mat_work[p*n+p];
         aqq = mat_work[q*n+q];
         apq = mat_work[p*n+q];
         half_angle_trig(2 * apq, aqq - app, c, s);
         for (int k = 0; k < n; k++) begin
            a = mat_work[k*n+p];
            b = mat_work[k*n+q];
            mat_work[k*n+p] = clip32(round_q30(c * a - s * b));
            mat_work[k*n+q] = clip32(round_q30(s * a + c * b));
         end
         for (int k = 0; k < n; k++) begin
            a = mat_work[p*n+k];
            b = mat_work[q*n+k];
            mat_work[p*n+k] = clip32(round_q30(c * a - s * b));
            mat_work[q*n+k] = clip32(round_q30(s * a + c * b));
         end
         c2 = round_q30(c * c);
         s2 = round_q30(s * s);
         sc2 = round_q30(2 * s * c);
         mat_work[p*n+p] = clip32(round_q30(c2 * app - sc2 * apq + s2 * aqq));
         mat_work[q*n+q] = clip32(round_q30(s2 * app + sc2 * apq + c2 * aqq));
         mat_work[p*n+q] = '0;
         mat_work[q*n+p] = '0;
         for (int k = 0; k < n; k++) begin
            a = mat_vec[k*n+p];
            b = mat_vec[k*n+q];
            mat_vec[k*n+p] = clip32(round_q30(c * a - s * b));
            mat_vec[k*n+q] = clip32(round_q30(s * a + c * b));
         end
      end
      for (int i = 0; i < n; i++) eig_vals[i] = mat_work[i*n+i];
      for (int i = 0; i < n; i++)
         for (int j = i + 1; j < n; j++)
            if (eig_vals[i] < eig_vals[j]) begin
               t = eig_vals[i]; eig_vals[i] = eig_vals[j]; eig_vals[j] = t;
               for (int r = 0; r < n; r++) begin
                  t = mat_vec[r*n+i];
                  mat_vec[r*n+i] = mat_vec[r*n+j];
                  mat_vec[r*n+j] = t;
               end
            end
   endfunction

   // Takes one accepted entry; a completed load queues all its eigenpair components.
   function automatic void predict_entry(input logic signed [31:0] e);
      int n;
      eigen_result_type res;
      if (load_pos == 0) begin
         n = cfg_size;
         if (n < 2) n = 2;
         if (n > MAX_N) n = MAX_N;
         dim_latched = n;
         for (int i = 0; i < n * n; i++)
            mat_vec[i] = (i / n == i % n) ? ONE_Q30 : 32'sd0;
      end
      n = dim_latched;
      mat_work[load_pos % DEPTH] = e;
      load_pos++;
      if (load_pos < n * n) return;
      load_pos = 0;
      solve_matrix();
      matrices_done++;
      for (int k = 0; k < n; k++)
         for (int r = 0; r < n; r++) begin
            res.pair_index = k[2:0];
            res.row_index = r[2:0];
            res.eigenvalue = eig_vals[k];
            res.component = mat_vec[r*n+k];
            res.last_of_run = (k == n - 1 && r == n - 1);
            expected_q.push_back(res);
         end
   endfunction

   // Driver: feeds queued entries in bursts with random gaps.
   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy) begin
            predict_entry(req_entry);
            entries_sent++;
         end
         if (!start || !busy) begin
            if (gap_left > 0) begin
               gap_left <= gap_left - 1;
               start <= 1'b0;
            end else if (entry_q.size() > 0) begin
               start <= 1'b1;
               req_entry <= entry_q.pop_front();
               if (burst_left <= 1) begin
                  burst_left <= $urandom_range(1, 40);
                  gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
               end else begin
                  burst_left <= burst_left - 1;
               end
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // Monitor: each strobed result is checked against the oldest expectation.
   always @(posedge clock) begin
      eigen_result_type exp_res;
      if (!reset && rsp_valid) begin
         if (expected_q.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected result: pair %0d row %0d", rsp_pair_index, rsp_row_index);
         end else begin
            exp_res = expected_q.pop_front();
            results_checked++;
            if (rsp_pair_index !== exp_res.pair_index || rsp_row_index !== exp_res.row_index ||
                rsp_eigenvalue !== exp_res.eigenvalue || rsp_component !== exp_res.component ||
                rsp_last_of_run !== exp_res.last_of_run) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch: exp k=%0d r=%0d ev=%h comp=%h last=%b got k=%0d r=%0d ev=%h comp=%h last=%b",
                           exp_res.pair_index, exp_res.row_index, exp_res.eigenvalue,
                           exp_res.component, exp_res.last_of_run, rsp_pair_index,
                           rsp_row_index, rsp_eigenvalue, rsp_component, rsp_last_of_run);
            end
         end
      end
   end

   // Watchdog on total run length.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb failed");
         $finish;
      end
   end

   // One APB register write: setup cycle, then access cycle.
   task automatic csr_write(input logic [3:0] addr, input logic [31:0] data);
      @(posedge clock);
      psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0; paddr <= addr; pwdata <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
      if (addr == ADDR_SIZE) cfg_size = data[3:0];
      else if (addr == ADDR_TOL) cfg_tol = data[15:0];
      else if (addr == ADDR_LIMIT) cfg_limit = data[7:0];
   endtask

   task automatic wait_sent();
      while (entry_q.size() != 0 || start) @(posedge clock);
   endtask

   task automatic wait_idle();
      wait_sent();
      while (expected_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic int load_dim();
      if (cfg_size < 2) return 2;
      if (cfg_size > MAX_N) return MAX_N;
      return cfg_size;
   endfunction

   // Queues one n-by-n matrix: symmetric with small or full-range values, or noise.
   task automatic queue_matrix(input int kind);
      int n, sh;
      logic signed [31:0] m [DEPTH];
      n = load_dim();
      sh = $urandom_range(0, 24);
      for (int i = 0; i < n; i++)
         for (int j = 0; j < n; j++) begin
            if (kind == 2 || j >= i)
               m[i*n+j] = (kind == 0) ? ($signed($urandom) >>> sh) : $signed($urandom);
            else
               m[i*n+j] = m[j*n+i];
         end
      for (int i = 0; i < n * n; i++) entry_q.push_back(m[i]);
   endtask

   initial begin
      int pick;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed: extremes of the entry field on a 2x2 at reset tolerance and limit.
      csr_write(ADDR_SIZE, 32'd2);
      entry_q.push_back(32'sh7fffffff); entry_q.push_back(32'sh80000000);
      entry_q.push_back(32'sh80000000); entry_q.push_back(32'sh7fffffff);
      wait_idle();
      // Zero off-diagonal and equal diagonal with zero tolerance: zero angle.
      csr_write(ADDR_TOL, 32'd0);
      entry_q.push_back(32'sh00010000); entry_q.push_back(32'sh0);
      entry_q.push_back(32'sh0); entry_q.push_back(32'sh00010000);
      wait_idle();
      // Rotation limit of zero sorts the diagonal as loaded; size 0 clamps to 2.
      csr_write(ADDR_LIMIT, 32'd0);
      csr_write(ADDR_SIZE, 32'd0);
      entry_q.push_back(32'sh00010000); entry_q.push_back(32'sh00020000);
      entry_q.push_back(32'sh00020000); entry_q.push_back(32'sh00050000);
      wait_idle();
      // Size change in the middle of a 3x3 load only affects the next load.
      csr_write(ADDR_LIMIT, 32'd255);
      csr_write(ADDR_TOL, 32'd1);
      csr_write(ADDR_SIZE, 32'd3);
      queue_matrix(0);
      repeat (4) void'(entry_q.pop_back());
      wait_sent();
      csr_write(ADDR_SIZE, 32'd1);
      queue_matrix(0);
      repeat (4) begin
         wait_sent();
         entry_q.push_back($signed($urandom) >>> 8);
      end
      wait_idle();
      // Largest tolerance: only off-diagonal magnitudes of at least 65535 start a rotation.
      csr_write(ADDR_TOL, 32'd65535);
      queue_matrix(0);
      wait_idle();

      // Random phase with occasional reconfiguration between loads.
      while (entries_sent + entry_q.size() < ITEM_TARGET) begin
         if ($urandom_range(0, 3) == 0) begin
            wait_idle();
            pick = $urandom_range(0, 19);
            if (pick == 0) csr_write(ADDR_SIZE, (pick & 1) ? 32'd8 : 32'd15);
            else if (pick == 1) csr_write(ADDR_SIZE, 32'd8);
            else if (pick < 4) csr_write(ADDR_SIZE, $urandom_range(0, 1));
            else if (pick < 6) csr_write(ADDR_SIZE, $urandom_range(9, 15) & 32'h7);
            else csr_write(ADDR_SIZE, $urandom_range(2, 5));
            csr_write(ADDR_TOL, ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                                           : $urandom_range(0, 64));
            csr_write(ADDR_LIMIT, ($urandom_range(0, 9) == 0) ? 32'd0
                                                             : $urandom_range(1, 255));
         end
         pick = $urandom_range(0, 9);
         queue_matrix((pick < 6) ? 0 : (pick < 8) ? 1 : 2);
         wait_sent();
      end
      wait_idle();

      $display("covered %0d matrices from %0d entries, %0d eigenpair components checked",
               matrices_done, entries_sent, results_checked);
      $display("mismatches: %0d, left over: %0d", mismatch_count, expected_q.size());
      if (mismatch_count == 0 && expected_q.size() == 0) begin
         $display("tb passed");
      end else begin
         $display("tb failed");
      end
      $finish;
   end
endmodule
